[rtl/cursor_list_store_macros.svh]
// Assertion macros used by the list store checker.
`ifndef CURSOR_LIST_STORE_MACROS_SVH
`define CURSOR_LIST_STORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CLS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked only while a result beat is on offer.
`define CLS_ASSERT_OUT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    out_valid_i |-> (cond)) else $error(msg);

`endif

[rtl/cls_pkg.sv]
// Shared types and constants of the cursor list store.
package cls_pkg;

  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  // cells folded into one register of the read tree
  localparam int unsigned RD_GROUP       = 8;

  typedef enum logic [3:0] {
    REQ_APPEND = 4'd0,
    REQ_INSERT = 4'd1,
    REQ_DELETE = 4'd2,
    REQ_READ   = 4'd3,
    REQ_WRITE  = 4'd4,
    REQ_GOTO   = 4'd5,
    REQ_FIRST  = 4'd6,
    REQ_NEXT   = 4'd7,
    REQ_PREV   = 4'd8,
    REQ_LAST   = 4'd9
  } req_e;

  // broadcast to all cells, only set for a beat that succeeds
  typedef struct packed {
    logic app;   // store at the end
    logic ins;   // store at cursor, shift up
    logic del;   // shift down onto cursor
    logic wr;    // overwrite at cursor
    logic rd;    // read at cursor
  } cls_op_t;

endpackage

[rtl/cls_cell.sv]
// One list cell: holds one entry and trades it with its neighbors.
module cls_cell import cls_pkg::*; #(
  parameter int unsigned DW  = DATA_WIDTH_DEF,
  parameter int unsigned CW  = 6,
  parameter int unsigned NW  = 7,
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  cls_op_t       op_i,
  input  logic [CW-1:0] cursor_i,
  input  logic [NW-1:0] count_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [DW-1:0] left_i,
  input  logic [DW-1:0] right_i,
  output logic [DW-1:0] data_o,
  output logic [DW-1:0] sel_data_o
);

  localparam logic [NW-1:0] IDX_N = NW'(IDX);
  localparam logic [NW-1:0] NXT_N = NW'(IDX + 1);

  logic [DW-1:0] data_q, data_d;
  logic [NW-1:0] cur_n;
  logic          at_cur, above_cur;

  assign cur_n     = NW'(cursor_i);
  assign at_cur    = (IDX_N == cur_n);
  assign above_cur = (IDX_N > cur_n);

  always_comb begin
    data_d = data_q;
    if ((op_i.app && (IDX_N == count_i)) || ((op_i.ins || op_i.wr) && at_cur)) begin
      data_d = wdata_i;
    end else if (op_i.ins && above_cur && (IDX_N <= count_i)) begin
      data_d = left_i;
    end else if (op_i.del && !(IDX_N < cur_n) && (NXT_N < count_i)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign sel_data_o = at_cur ? data_q : '0;

endmodule

[rtl/cls_rdtree.sv]
// Two-level registered OR tree that collects the entry under the cursor.
module cls_rdtree import cls_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned DW    = DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          load_i,
  input  logic [DW-1:0] sel_i [DEPTH],
  output logic [DW-1:0] rd_data_o
);

  localparam int unsigned NG = (DEPTH + RD_GROUP - 1) / RD_GROUP;

  logic [DW-1:0] grp_d [NG];
  logic [DW-1:0] grp_q [NG];

  // first level: each group of cells, at most one cell is non-zero
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < RD_GROUP; k++) begin
        if (g * RD_GROUP + k < DEPTH) begin
          grp_d[g] = grp_d[g] | sel_i[g * RD_GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  // second level: fold the group registers
  always_comb begin
    rd_data_o = '0;
    for (int g = 0; g < NG; g++) begin
      rd_data_o = rd_data_o | grp_q[g];
    end
  end

endmodule

[rtl/cls_ctrl.sv]
// Request decoder with the count and cursor registers.
module cls_ctrl import cls_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned CW    = 6,
  parameter int unsigned NW    = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [3:0]    req_type_i,
  input  logic [CW-1:0] target_pos_i,
  output cls_op_t       op_o,
  output logic          ok_o,
  output logic [CW-1:0] cursor_o,
  output logic [NW-1:0] count_o,
  output logic [CW-1:0] cursor_nxt_o,
  output logic [NW-1:0] count_nxt_o
);

  logic [CW-1:0] cursor_q, cursor_d;
  logic [NW-1:0] count_q, count_d;
  logic [NW-1:0] cur_n, cnt_m1;
  logic          cur_in, full, ok;
  cls_op_t       op;

  assign cur_n  = NW'(cursor_q);
  assign cnt_m1 = count_q - NW'(1);
  assign cur_in = (cur_n < count_q);
  assign full   = (count_q == NW'(DEPTH));

  always_comb begin
    ok       = 1'b0;
    op       = '0;
    cursor_d = cursor_q;
    count_d  = count_q;
    unique case (req_e'(req_type_i))
      REQ_APPEND: begin
        ok      = !full;
        op.app  = 1'b1;
        count_d = count_q + NW'(1);
      end
      REQ_INSERT: begin
        ok      = !full && (cur_n <= count_q);
        op.ins  = 1'b1;
        count_d = count_q + NW'(1);
      end
      REQ_DELETE: begin
        ok      = cur_in;
        count_d = cnt_m1;
        if (cur_n == cnt_m1) begin
          // last entry goes: step back unless at the head
          if (cnt_m1 != '0) begin
            cursor_d = cursor_q - CW'(1);
          end
        end else begin
          op.del = 1'b1;
        end
      end
      REQ_READ: begin
        ok    = cur_in;
        op.rd = 1'b1;
      end
      REQ_WRITE: begin
        ok    = cur_in;
        op.wr = 1'b1;
      end
      REQ_GOTO: begin
        ok       = (NW'(target_pos_i) < count_q);
        cursor_d = target_pos_i;
      end
      REQ_FIRST: begin
        ok       = (count_q != '0);
        cursor_d = '0;
      end
      REQ_NEXT: begin
        ok       = ((cur_n + NW'(1)) < count_q);
        cursor_d = cursor_q + CW'(1);
      end
      REQ_PREV: begin
        ok       = (cursor_q != '0);
        cursor_d = cursor_q - CW'(1);
      end
      REQ_LAST: begin
        ok       = (count_q != '0);
        cursor_d = CW'(cnt_m1);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    // a rejected request changes nothing
    if (!ok) begin
      op       = '0;
      cursor_d = cursor_q;
      count_d  = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      count_q  <= '0;
    end else if (acc_i) begin
      cursor_q <= cursor_d;
      count_q  <= count_d;
    end
  end

  assign op_o         = acc_i ? op : '0;
  assign ok_o         = ok;
  assign cursor_o     = cursor_q;
  assign count_o      = count_q;
  assign cursor_nxt_o = cursor_d;
  assign count_nxt_o  = count_d;

endmodule

[rtl/cursor_list_store.sv]
// Top level of the cursor list store: decoder, cell chain, read tree, result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | to block  | in_valid_i / in_ready_o    | req_type_i, write_data_i, target_pos_i
//  out     | from block| out_valid_o / out_ready_i  | ok_o, read_data_o, cursor_pos_o,
//          |           |                            | item_count_o
//
// Cycles: one beat per cycle for every request but a successful read, while the
// result side keeps up. Insert and delete shift all cells at once, so they finish
// in the accept cycle. A successful read loads the two-level OR tree that gathers
// the entry under the cursor, then the result register; in_ready_o is low between.
// Reset clears count, cursor and the out-valid and read-busy flags only; cells hold
// no reset and need no clearing pass. A stalled result sits in the output register;
// the next request is still taken in the cycle the result leaves.
module cursor_list_store import cls_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned CW        = $clog2(DEPTH),
  localparam int unsigned NW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [3:0]            req_type_i,
  input  logic [DATA_WIDTH-1:0] write_data_i,
  input  logic [CW-1:0]         target_pos_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ok_o,
  output logic [DATA_WIDTH-1:0] read_data_o,
  output logic [CW-1:0]         cursor_pos_o,
  output logic [NW-1:0]         item_count_o
);

  logic                  acc;
  cls_op_t               op;
  logic                  dec_ok;
  logic [CW-1:0]         cursor, cursor_nxt;
  logic [NW-1:0]         count, count_nxt;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_sel  [DEPTH];
  logic [DATA_WIDTH-1:0] tree_data;

  // result register and read-in-flight flag
  logic                  out_valid_q, out_valid_d;
  logic                  rd_busy_q, rd_busy_d;
  logic                  ok_q, ok_d;
  logic [DATA_WIDTH-1:0] rdata_q, rdata_d;
  logic [CW-1:0]         cur_q, cur_d;
  logic [NW-1:0]         cnt_q, cnt_d;

  // no intake while a read drains the tree or a result is stuck
  assign in_ready_o = !rd_busy_q && (!out_valid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;

  cls_ctrl #(
    .DEPTH(DEPTH),
    .CW   (CW),
    .NW   (NW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .req_type_i  (req_type_i),
    .target_pos_i(target_pos_i),
    .op_o        (op),
    .ok_o        (dec_ok),
    .cursor_o    (cursor),
    .count_o     (count),
    .cursor_nxt_o(cursor_nxt),
    .count_nxt_o (count_nxt)
  );

  // cell chain: cell i takes from i-1 on insert and from i+1 on delete
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[i+1];
    end

    cls_cell #(
      .DW (DATA_WIDTH),
      .CW (CW),
      .NW (NW),
      .IDX(i)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (op),
      .cursor_i  (cursor),
      .count_i   (count),
      .wdata_i   (write_data_i),
      .left_i    (left),
      .right_i   (right),
      .data_o    (cell_data[i]),
      .sel_data_o(cell_sel[i])
    );
  end

  cls_rdtree #(
    .DEPTH(DEPTH),
    .DW   (DATA_WIDTH)
  ) u_rdtree (
    .clk_i    (clk_i),
    .load_i   (op.rd),
    .sel_i    (cell_sel),
    .rd_data_o(tree_data)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    rd_busy_d   = 1'b0;
    ok_d        = ok_q;
    rdata_d     = rdata_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    if (acc && op.rd) begin
      // result follows next cycle once the tree is loaded
      rd_busy_d = 1'b1;
    end else if (acc) begin
      out_valid_d = 1'b1;
      ok_d        = dec_ok;
      rdata_d     = '0;
      cur_d       = cursor_nxt;
      cnt_d       = count_nxt;
    end else if (rd_busy_q) begin
      // read leaves count and cursor as they were
      out_valid_d = 1'b1;
      ok_d        = 1'b1;
      rdata_d     = tree_data;
      cur_d       = cursor;
      cnt_d       = count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rd_busy_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      rd_busy_q   <= rd_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q    <= ok_d;
    rdata_q <= rdata_d;
    cur_q   <= cur_d;
    cnt_q   <= cnt_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign read_data_o  = rdata_q;
  assign cursor_pos_o = cur_q;
  assign item_count_o = cnt_q;

endmodule

[rtl/cls_checker.sv]
// Port-level checker for the cursor list store, bound to the top level.
`include "cursor_list_store_macros.svh"

module cls_checker import cls_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned CW        = $clog2(DEPTH),
  localparam int unsigned NW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  ok_i,
  input  logic [DATA_WIDTH-1:0] read_data_i,
  input  logic [CW-1:0]         cursor_i,
  input  logic [NW-1:0]         count_i
);

  logic          have_q;
  logic [NW-1:0] last_cnt_q;

  // count of the previous result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q     <= 1'b0;
      last_cnt_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      have_q     <= 1'b1;
      last_cnt_q <= count_i;
    end
  end

  `CLS_ASSERT_OUT(a_count_range, count_i <= NW'(DEPTH), "item count above capacity")

  `CLS_ASSERT_OUT(a_cursor_in_list,
    ((count_i == '0) && (cursor_i == '0)) || (NW'(cursor_i) < count_i),
    "cursor outside the list")

  `CLS_ASSERT_OUT(a_reject_no_data, ok_i || (read_data_i == '0),
    "rejected request carries read data")

  `CLS_ASSERT_OUT(a_count_step,
    !have_q || (count_i == last_cnt_q) || (count_i == last_cnt_q + NW'(1)) ||
    (count_i + NW'(1) == last_cnt_q),
    "item count moved by more than one")

  `CLS_ASSERT(a_out_hold,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(count_i) && $stable(cursor_i),
    "stalled result beat changed")

endmodule

bind cursor_list_store cls_checker #(
  .DEPTH     (DEPTH),
  .DATA_WIDTH(DATA_WIDTH)
) u_cls_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .ok_i       (ok_o),
  .read_data_i(read_data_o),
  .cursor_i   (cursor_pos_o),
  .count_i    (item_count_o)
);

[tb/sv/tb_cursor_list_store.sv]
// Self-checking testbench of the cursor list store: directed and random requests, scored.
`timescale 1ns / 100ps

module tb_cursor_list_store;
  import cls_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;
  localparam int unsigned DW         = DATA_WIDTH_DEF;
  localparam int unsigned CW         = $clog2(LIST_DEPTH);
  localparam int unsigned NW         = $clog2(LIST_DEPTH + 1);

  // request codes the block must refuse
  localparam logic [3:0] REQ_UNUSED_LO = 4'd10;
  localparam logic [3:0] REQ_UNUSED_HI = 4'd15;

  localparam int unsigned MAX_GAP      = 8;
  localparam int unsigned HOLD_CYCLES  = 120;     // long sink stall for the pressure test
  localparam int unsigned DRAIN_CYCLES = 16;      // result register plus the read through the OR tree
  localparam int unsigned CYCLE_LIMIT  = 300_000;
  localparam int unsigned MAX_REPORTS  = 10;

  // one result beat, as the list should answer it
  typedef struct packed {
    logic          ok;
    logic [DW-1:0] rdata;
    logic [CW-1:0] cursor;
    logic [NW-1:0] count;
  } list_result_t;

  logic          clk_i        = 1'b0;
  logic          rst_ni       = 1'b0;
  logic          in_valid_i   = 1'b0;
  logic          in_ready_o;
  logic [3:0]    req_type_i   = '0;
  logic [DW-1:0] write_data_i = '0;
  logic [CW-1:0] target_pos_i = '0;
  logic          out_valid_o;
  logic          out_ready_i  = 1'b0;
  logic          ok_o;
  logic [DW-1:0] read_data_o;
  logic [CW-1:0] cursor_pos_o;
  logic [NW-1:0] item_count_o;

  cursor_list_store dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .write_data_i (write_data_i),
    .target_pos_i (target_pos_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .read_data_o  (read_data_o),
    .cursor_pos_o (cursor_pos_o),
    .item_count_o (item_count_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow list: contents, fill level and cursor as the block should hold them.
  // Updated at the edge a request beat is accepted, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] list_mem [LIST_DEPTH];
  int unsigned   list_count  = 0;
  int unsigned   list_cursor = 0;

  list_result_t  expected_results [$];

  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;

  // idle control: gaps on the request side and stalls on the result side
  bit            tx_gaps = 1'b1;
  bit            rx_gaps = 1'b1;
  // pressure: each request bumps hold_requests, the sink serves it with one long stall
  int unsigned   hold_requests = 0;
  int unsigned   holds_served  = 0;
  int unsigned   sink_wait     = 0;

  // cursor move; refused when the target is past the last entry
  function automatic logic seek_cursor(int unsigned pos);
    if (pos >= list_count) return 1'b0;
    list_cursor = pos;
    return 1'b1;
  endfunction

  // apply one request to the shadow list and return the result it must give
  function automatic list_result_t apply_request(logic [3:0] req, logic [DW-1:0] wdata,
                                                 logic [CW-1:0] tpos);
    list_result_t res;
    int unsigned  i;
    res = '0;
    case (req)
      REQ_APPEND: begin
        if (list_count < LIST_DEPTH) begin
          list_mem[list_count] = wdata;
          list_count++;
          res.ok = 1'b1;
        end
      end
      REQ_INSERT: begin
        // later entries move up one cell; an empty list takes the entry at 0
        if (list_count < LIST_DEPTH) begin
          for (i = list_count; i > list_cursor; i--) list_mem[i] = list_mem[i-1];
          list_mem[list_cursor] = wdata;
          list_count++;
          res.ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (list_count > 0 && list_cursor < list_count) begin
          list_count--;
          if (list_count > 0) begin
            // on the last entry the cursor steps back, else the tail moves down
            if (list_cursor == list_count) begin
              list_cursor--;
            end else begin
              for (i = list_cursor; i < list_count; i++) list_mem[i] = list_mem[i+1];
            end
          end
          res.ok = 1'b1;
        end
      end
      REQ_READ: begin
        if (list_count > 0 && list_cursor < list_count) begin
          res.rdata = list_mem[list_cursor];
          res.ok    = 1'b1;
        end
      end
      REQ_WRITE: begin
        if (list_count > 0 && list_cursor < list_count) begin
          list_mem[list_cursor] = wdata;
          res.ok = 1'b1;
        end
      end
      REQ_GOTO:  res.ok = seek_cursor(tpos);
      REQ_FIRST: res.ok = seek_cursor(0);
      REQ_NEXT:  res.ok = seek_cursor(list_cursor + 1);
      REQ_PREV: begin
        if (list_cursor > 0) res.ok = seek_cursor(list_cursor - 1);
      end
      REQ_LAST: begin
        if (list_count > 0) res.ok = seek_cursor(list_count - 1);
      end
      default: ;  // unused codes: refused, nothing moves
    endcase
    res.cursor = list_cursor[CW-1:0];
    res.count  = list_count[NW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Called at a rising edge; returns at the edge the beat is taken,
  // with valid still high so a back-to-back beat keeps it up.
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [3:0] req, logic [DW-1:0] wdata, logic [CW-1:0] tpos);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    write_data_i <= wdata;
    target_pos_i <= tpos;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(apply_request(req, wdata, tpos));
  endtask

  // ---------------------------------------------------------------------------
  // Result side. Each taken beat draws a stall for the next one; a pending hold
  // request turns into one long stall, so the block backs up onto its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_sink
    if (out_valid_o && out_ready_i) sink_wait = rx_gaps ? $urandom_range(MAX_GAP, 0) : 0;
    if (sink_wait == 0 && hold_requests != holds_served) begin
      sink_wait = HOLD_CYCLES;
      holds_served++;
    end
    if (sink_wait > 0) begin
      sink_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Scoreboard: every taken result beat against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] result beat with nothing expected: ok=%0b rd=%h cur=%0d cnt=%0d",
                   $realtime, ok_o, read_data_o, cursor_pos_o, item_count_o);
      end else begin
        want = expected_results.pop_front();
        if (ok_o !== want.ok || read_data_o !== want.rdata ||
            cursor_pos_o !== want.cursor || item_count_o !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: want ok=%0b rd=%h cur=%0d cnt=%0d, got ok=%0b rd=%h cur=%0d cnt=%0d",
                     $realtime, want.ok, want.rdata, want.cursor, want.count,
                     ok_o, read_data_o, cursor_pos_o, item_count_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL cursor_list_store");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every request but append and insert against an empty list: each must be refused.
  task automatic test_empty_requests();
    send_request(REQ_READ,   '0, '0);
    send_request(REQ_WRITE,  '1, '0);
    send_request(REQ_DELETE, '0, '0);
    send_request(REQ_FIRST,  '0, '0);
    send_request(REQ_LAST,   '0, '0);
    send_request(REQ_NEXT,   '0, '0);
    send_request(REQ_PREV,   '0, '0);
    send_request(REQ_GOTO,   '0, '0);
    send_request(REQ_GOTO,   '0, '1);
    send_request(REQ_UNUSED_LO, '1, '1);
    send_request(REQ_UNUSED_HI, '0, '0);
  endtask

  // Small edits on a short list; data extremes, cursor walks and both delete paths.
  task automatic test_edit_basics();
    send_request(REQ_INSERT, 32'hA5A5_5A5A, '0);  // empty list: lands at 0
    send_request(REQ_APPEND, 32'h0000_0000, '0);
    send_request(REQ_APPEND, 32'hFFFF_FFFF, '0);
    send_request(REQ_LAST,   '0, '0);
    send_request(REQ_READ,   '0, '0);
    send_request(REQ_GOTO,   '0, 6'd1);
    send_request(REQ_INSERT, 32'h5A5A_A5A5, '0);
    send_request(REQ_READ,   '0, '0);
    send_request(REQ_WRITE,  32'hFFFF_FFFF, '0);
    send_request(REQ_READ,   '0, '0);
    send_request(REQ_NEXT,   '0, '0);
    send_request(REQ_NEXT,   '0, '0);
    send_request(REQ_NEXT,   '0, '0);             // past the end
    send_request(REQ_DELETE, '0, '0);             // on last entry: cursor steps back
    send_request(REQ_GOTO,   '0, 6'd3);           // now out of range
    send_request(REQ_FIRST,  '0, '0);
    send_request(REQ_PREV,   '0, '0);             // already at 0
    send_request(REQ_DELETE, '0, '0);             // tail shifts down
    send_request(REQ_READ,   '0, '0);
    send_request(REQ_DELETE, '0, '0);
    send_request(REQ_DELETE, '0, '0);             // last one out, cursor stays 0
    send_request(REQ_READ,   '0, '0);
  endtask

  // Fill to capacity, bounce off the full list, then empty it from random spots.
  task automatic test_full_list();
    while (list_count < LIST_DEPTH) send_request(REQ_APPEND, $urandom(), '0);
    send_request(REQ_APPEND, $urandom(), '0);
    send_request(REQ_INSERT, $urandom(), '0);
    send_request(REQ_GOTO,   '0, '1);
    send_request(REQ_READ,   '0, '0);
    send_request(REQ_NEXT,   '0, '0);
    send_request(REQ_WRITE,  $urandom(), '0);
    send_request(REQ_DELETE, '0, '0);
    send_request(REQ_INSERT, $urandom(), '0);     // refills at the cursor
    while (list_count > 0) begin
      if ($urandom_range(1, 0))
        send_request(REQ_GOTO, '0, CW'($urandom_range(list_count - 1, 0)));
      send_request(REQ_DELETE, '0, '0);
    end
  endtask

  // Sink stalls for a long stretch while requests keep coming back to back.
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    hold_requests++;
    repeat (12) send_request(REQ_APPEND, $urandom(), '0);
    repeat (6) begin
      send_request(REQ_GOTO, '0, CW'($urandom_range(list_count - 1, 0)));
      send_request(REQ_READ, '0, '0);
      send_request(REQ_INSERT, $urandom(), '0);
    end
    tx_gaps = 1'b1;
  endtask

  // Random requests in phases that push the fill level up and back down, so the
  // list spends time near empty and full; one phase runs with no idling at all.
  task automatic test_random_mix();
    int unsigned   grow_w;
    int unsigned   del_w;
    int unsigned   pick;
    logic [3:0]    req;
    logic [DW-1:0] wdata;
    logic [CW-1:0] tpos;
    for (int phase = 0; phase < 6; phase++) begin
      grow_w  = (phase % 2 == 0) ? 45 : 15;
      del_w   = (phase % 2 == 0) ? 12 : 40;
      tx_gaps = (phase != 2);
      rx_gaps = (phase != 2);
      repeat (250) begin
        pick  = $urandom_range(99, 0);
        wdata = $urandom();
        tpos  = CW'($urandom_range(LIST_DEPTH - 1, 0));
        if (pick < grow_w) begin
          req = $urandom_range(1, 0) ? REQ_INSERT : REQ_APPEND;
        end else if (pick < grow_w + del_w) begin
          req = REQ_DELETE;
        end else begin
          case ($urandom_range(9, 0))
            0, 1:    req = REQ_READ;
            2:       req = REQ_WRITE;
            3, 4:    req = REQ_GOTO;
            5:       req = REQ_FIRST;
            6:       req = REQ_NEXT;
            7:       req = REQ_PREV;
            8:       req = REQ_LAST;
            default: req = 4'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
          endcase
        end
        // goto mostly lands inside the list, sometimes anywhere
        if (req == REQ_GOTO && list_count > 0 && $urandom_range(3, 0) != 0)
          tpos = CW'($urandom_range(list_count - 1, 0));
        send_request(req, wdata, tpos);
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin : run_tests
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_requests();
    test_edit_basics();
    test_full_list();
    test_backpressure();
    test_random_mix();

    // drain: all results back, then a few quiet cycles for stray beats
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS cursor_list_store");
    end else begin
      $display("FAIL cursor_list_store");
    end
    $finish;
  end

endmodule
